// ----- sv/psrr_pkg.sv -----
// Shared types and constants for the process slot round-robin scheduler.
`timescale 1ns / 1ps

package psrr_pkg;

    // Default sizing of the slot table.
    localparam int SLOTS_DEF    = 16;
    localparam int PID_BITS_DEF = 16;

    // Fixed field widths of the beats.
    localparam int KPID_W   = 16;
    localparam int SLOT_W   = 4;

    typedef enum logic [1:0] {
        CMD_CREATE    = 2'd0,
        CMD_YIELD     = 2'd1,
        CMD_EXIT      = 2'd2,
        CMD_TERMINATE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_FULL      = 3'd1,
        STS_NO_SWITCH = 3'd2,
        STS_ROOT      = 3'd3,
        STS_NOT_FOUND = 3'd4
    } t_status;

    typedef struct packed {
        t_cmd               cmd;
        logic [KPID_W-1:0]  kill_pid;
    } t_in_beat;

    typedef struct packed {
        t_status            status;
        logic [KPID_W-1:0]  new_pid;
        logic               switched;
        logic [SLOT_W-1:0]  from_slot;
        logic [SLOT_W-1:0]  to_slot;
    } t_out_beat;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_DISP   = 3'd1,
        S_SCAN   = 3'd2,
        S_KREAD  = 3'd3,
        S_KCMP   = 3'd4,
        S_FINISH = 3'd5
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic mark_exit;
        logic step;
        logic commit;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        t_cmd cmd;
        logic kpid_zero;
        logic hit;
        logic last;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- sv/process_slot_round_robin_scheduler_core.sv -----
// Top level of the process slot round-robin scheduler.
// Sequence: accept in idle, a dispatch state, then the slot scan, then a commit state.
// Create, yield and exit scan one slot a cycle.
// Kill reads the pid store and then compares, a read state and a compare state per slot.
// A new beat is taken only after the commit; an unread result delays the commit.
// Reset (synchronous, active low): slot 0 running with pid 0, all else empty, pid counter 1.
`timescale 1ns / 1ps

module process_slot_round_robin_scheduler_core #(
    parameter int SLOTS    = psrr_pkg::SLOTS_DEF,
    parameter int PID_BITS = psrr_pkg::PID_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  psrr_pkg::t_in_beat   i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output psrr_pkg::t_out_beat  o_out_beat
);

    // Command and status between the sequencer and the slot datapath.
    psrr_pkg::t_dp_cmd dp_cmd;
    psrr_pkg::t_dp_sts dp_sts;

    // Sequencer: accepts a beat only in idle, walks the scan, and
    // holds the commit until the output register is free.
    psrr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall)
    );

    // Datapath: slot flags in flops, pids in a store with one write port and a
    // registered read, round-robin index arithmetic and the result register.
    psrr_dp #(
        .SLOTS    (SLOTS),
        .PID_BITS (PID_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_beat   (i_in_beat),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat)
    );

    // A taken beat moves the sequencer out of idle at once.
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an accepted beat");

    // A switch is always a successful yield or exit.
    a_switch_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.switched) |-> (o_out_beat.status == psrr_pkg::STS_OK))
        else $error("switch reported with a failing status");

    // Without a switch the current slot must not move.
    a_no_switch_same_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_beat.switched)
        |-> (o_out_beat.from_slot == o_out_beat.to_slot))
        else $error("current slot changed without a switch");

    // A pid is handed out only by a successful create.
    a_pid_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.new_pid != '0) |-> (o_out_beat.status == psrr_pkg::STS_OK))
        else $error("new pid reported with a failing status");

    // Commit happens only when the output register can take the result.
    a_commit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.commit |-> (!o_out_valid || !i_out_stall))
        else $error("result committed over an unread beat");

endmodule

// ----- sv/psrr_ctrl.sv -----
// Sequencing state machine for the scheduler: dispatch, slot scan, commit.
`timescale 1ns / 1ps

module psrr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  psrr_pkg::t_dp_sts  i_sts,
    output psrr_pkg::t_dp_cmd  o_cmd,
    output logic               o_in_stall
);

    psrr_pkg::t_state r_state;
    psrr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psrr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            psrr_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = psrr_pkg::S_DISP;
                end
            end
            psrr_pkg::S_DISP: begin
                unique case (i_sts.cmd) inside
                    psrr_pkg::CMD_CREATE, psrr_pkg::CMD_YIELD: begin
                        n_state = psrr_pkg::S_SCAN;
                    end
                    psrr_pkg::CMD_EXIT: begin
                        // retire the current slot before the search
                        o_cmd.mark_exit = 1'b1;
                        n_state         = psrr_pkg::S_SCAN;
                    end
                    default: begin
                        n_state = i_sts.kpid_zero ? psrr_pkg::S_FINISH : psrr_pkg::S_KREAD;
                    end
                endcase
            end
            psrr_pkg::S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_sts.hit || i_sts.last) begin
                    n_state = psrr_pkg::S_FINISH;
                end
            end
            psrr_pkg::S_KREAD: begin
                n_state = psrr_pkg::S_KCMP;
            end
            psrr_pkg::S_KCMP: begin
                o_cmd.step = 1'b1;
                n_state    = (i_sts.hit || i_sts.last) ? psrr_pkg::S_FINISH
                                                       : psrr_pkg::S_KREAD;
            end
            psrr_pkg::S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = psrr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = psrr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/psrr_dp.sv -----
// Slot table, pid memory, scan index, pid counter and result register.
`timescale 1ns / 1ps

module psrr_dp #(
    parameter int SLOTS    = psrr_pkg::SLOTS_DEF,
    parameter int PID_BITS = psrr_pkg::PID_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  psrr_pkg::t_in_beat   i_in_beat,
    input  psrr_pkg::t_dp_cmd    i_cmd,
    output psrr_pkg::t_dp_sts    o_sts,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output psrr_pkg::t_out_beat  o_out_beat
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = (PID_BITS > psrr_pkg::KPID_W) ? PID_BITS : psrr_pkg::KPID_W;
    localparam int XW = (IW > psrr_pkg::SLOT_W) ? IW : psrr_pkg::SLOT_W;

    // slot flags: running is used, not ready and not zombie
    logic [SLOTS-1:0]           r_used;
    logic [SLOTS-1:0]           r_ready;
    logic [SLOTS-1:0]           r_zomb;
    logic [IW-1:0]              r_run;
    logic [PID_BITS-1:0]        r_pid_cnt;
    logic                       r_pid0_wr;

    logic [PID_BITS-1:0]        r_pid_mem [SLOTS];
    logic [PID_BITS-1:0]        r_rd_pid;

    psrr_pkg::t_cmd             r_cmd;
    logic [psrr_pkg::KPID_W-1:0] r_kpid;
    logic [IW-1:0]              r_k;
    logic                       r_found;
    logic [IW-1:0]              r_fidx;

    logic                       r_out_vld;
    psrr_pkg::t_out_beat        r_out;
    psrr_pkg::t_out_beat        n_out;

    logic [IW:0]                rr_sum;
    logic [IW-1:0]              rr_idx;
    logic [IW-1:0]              idx;
    logic                       hit;
    logic                       last;
    logic                       out_free;
    logic                       run_live;
    logic                       sw;
    logic [IW-1:0]              n_run;
    logic [CW-1:0]              pid_ext;
    logic [XW-1:0]              from_ext;
    logic [XW-1:0]              to_ext;

    // round-robin index: current slot plus one plus step count, wrapped
    assign rr_sum = {1'b0, r_run} + (IW+1)'(1) + {1'b0, r_k};
    assign rr_idx = (rr_sum >= (IW+1)'(SLOTS)) ? IW'(rr_sum - (IW+1)'(SLOTS))
                                               : rr_sum[IW-1:0];
    assign idx    = (r_cmd == psrr_pkg::CMD_YIELD || r_cmd == psrr_pkg::CMD_EXIT) ? rr_idx
                                                                                  : r_k;
    assign last   = (r_k == IW'(SLOTS - 1));
    assign out_free = !r_out_vld || !i_out_stall;

    always_comb begin
        case (r_cmd) inside
            psrr_pkg::CMD_CREATE: begin
                hit = !r_used[idx] || r_zomb[idx];
            end
            psrr_pkg::CMD_YIELD, psrr_pkg::CMD_EXIT: begin
                hit = r_used[idx] && r_ready[idx];
            end
            default: begin
                // slot 0 holds pid 0 until a create writes it
                hit = r_used[r_k] && !r_zomb[r_k] && (r_k != '0 || r_pid0_wr)
                      && (CW'(r_rd_pid) == CW'(r_kpid));
            end
        endcase
    end

    assign o_sts.cmd       = r_cmd;
    assign o_sts.kpid_zero = (r_kpid == '0);
    assign o_sts.hit       = hit;
    assign o_sts.last      = last;
    assign o_sts.out_free  = out_free;

    assign run_live = r_used[r_run] && !r_ready[r_run] && !r_zomb[r_run];
    assign sw       = r_found && (r_fidx != r_run)
                      && (r_cmd == psrr_pkg::CMD_YIELD || r_cmd == psrr_pkg::CMD_EXIT);
    assign n_run    = sw ? r_fidx : r_run;
    assign pid_ext  = CW'(r_pid_cnt);
    assign from_ext = XW'(r_run);
    assign to_ext   = XW'(n_run);

    always_comb begin
        n_out           = '0;
        n_out.from_slot = from_ext[psrr_pkg::SLOT_W-1:0];
        n_out.to_slot   = to_ext[psrr_pkg::SLOT_W-1:0];
        n_out.switched  = sw;
        case (r_cmd) inside
            psrr_pkg::CMD_CREATE: begin
                if (r_found) begin
                    n_out.status  = psrr_pkg::STS_OK;
                    n_out.new_pid = pid_ext[psrr_pkg::KPID_W-1:0];
                end else begin
                    n_out.status  = psrr_pkg::STS_FULL;
                end
            end
            psrr_pkg::CMD_YIELD, psrr_pkg::CMD_EXIT: begin
                n_out.status = sw ? psrr_pkg::STS_OK : psrr_pkg::STS_NO_SWITCH;
            end
            default: begin
                if (r_kpid == '0) begin
                    n_out.status = psrr_pkg::STS_ROOT;
                end else if (r_found) begin
                    n_out.status = psrr_pkg::STS_OK;
                end else begin
                    n_out.status = psrr_pkg::STS_NOT_FOUND;
                end
            end
        endcase
    end

    // item registers and scan progress
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_in_beat.cmd;
            r_kpid  <= i_in_beat.kill_pid;
            r_k     <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.step) begin
            if (hit) begin
                r_found <= 1'b1;
                r_fidx  <= idx;
            end else if (!last) begin
                r_k <= r_k + IW'(1);
            end
        end
    end

    // pid store and its registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_cmd == psrr_pkg::CMD_CREATE && r_found) begin
            r_pid_mem[r_fidx] <= r_pid_cnt;
        end
        r_rd_pid <= r_pid_mem[r_k];
    end

    // slot flags, current slot and pid counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= SLOTS'(1);
            r_ready   <= '0;
            r_zomb    <= ~SLOTS'(1);
            r_run     <= '0;
            r_pid_cnt <= PID_BITS'(1);
            r_pid0_wr <= 1'b0;
        end else begin
            if (i_cmd.mark_exit) begin
                r_zomb[r_run]  <= 1'b1;
                r_ready[r_run] <= 1'b0;
            end
            if (i_cmd.commit) begin
                case (r_cmd) inside
                    psrr_pkg::CMD_CREATE: begin
                        if (r_found) begin
                            r_used[r_fidx]  <= 1'b1;
                            r_ready[r_fidx] <= 1'b1;
                            r_zomb[r_fidx]  <= 1'b0;
                            if (r_fidx == '0) begin
                                r_pid0_wr <= 1'b1;
                            end
                            r_pid_cnt <= (r_pid_cnt == '1) ? PID_BITS'(1)
                                                           : r_pid_cnt + PID_BITS'(1);
                        end
                    end
                    psrr_pkg::CMD_YIELD, psrr_pkg::CMD_EXIT: begin
                        if (sw) begin
                            if (run_live) begin
                                r_ready[r_run] <= 1'b1;
                            end
                            r_ready[r_fidx] <= 1'b0;
                            r_run           <= r_fidx;
                        end
                    end
                    default: begin
                        if (r_found) begin
                            r_zomb[r_fidx]  <= 1'b1;
                            r_ready[r_fidx] <= 1'b0;
                        end
                    end
                endcase
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out;

endmodule
